// ===== rtl/ust_pkg.sv =====
// ----------------------------------------------------------------------------
// ust_pkg
// Shared widths, codes, CORDIC constants and beat types of the UV sphere
// tessellator.
// ----------------------------------------------------------------------------
package ust_pkg;

   localparam int CNT_W    = 9;
   localparam int RAD_W    = 16;
   localparam int ANG_W    = 32;
   localparam int CW       = 34;
   localparam int CS_W     = 32;
   localparam int POS_W    = 17;
   localparam int NRM_W    = 16;
   localparam int VIX_W    = 17;
   localparam int KIND_W   = 2;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;
   localparam int STEP_W   = 3;

   localparam int MAX_SECTORS      = 256;
   localparam int MAX_STACKS       = 256;
   localparam int MIN_SECTORS      = 3;
   localparam int MIN_STACKS       = 2;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_MAX       = 24;

   // The two dividers run 32 quotient bits over four stages.
   localparam int DIV_STG     = 4;
   localparam int DIV_PER_STG = ANG_W / DIV_STG;

   localparam int POS_LIM = 65535;
   localparam int NRM_LIM = 32767;

   localparam logic [KIND_W-1:0] KIND_VERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TRI  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

   localparam logic [1:0] REG_RADIUS  = 2'd0;
   localparam logic [1:0] REG_SECTORS = 2'd1;
   localparam logic [1:0] REG_STACKS  = 2'd2;

   localparam logic [RAD_W-1:0] RADIUS_RST  = 16'd256;
   localparam logic [CNT_W-1:0] SECTORS_RST = 9'd36;
   localparam logic [CNT_W-1:0] STACKS_RST  = 9'd18;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_TURNS [CORDIC_MAX] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   typedef struct packed {
      logic             err;
      logic             top_en;
      logic             bot_en;
      logic [VIX_W-1:0] k1;
   } meta_type;

   typedef struct packed {
      meta_type                meta;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [NRM_W-1:0] norm_x;
      logic signed [NRM_W-1:0] norm_y;
      logic signed [NRM_W-1:0] norm_z;
   } vert_type;

endpackage

// ===== rtl/ust_emitter.sv =====
// ----------------------------------------------------------------------------
// ust_emitter
// Holds one finished grid point and sends its vertex beat followed by the
// triangle corner beats of its cell, or a single error beat if out of range.
// ----------------------------------------------------------------------------
module ust_emitter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [ust_pkg::CNT_W-1:0]             ns,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  ust_pkg::vert_type                     in_vert,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ust_pkg::KIND_W-1:0]            rsp_kind,
   output logic signed [ust_pkg::POS_W-1:0]      rsp_pos_x,
   output logic signed [ust_pkg::POS_W-1:0]      rsp_pos_y,
   output logic signed [ust_pkg::POS_W-1:0]      rsp_pos_z,
   output logic signed [ust_pkg::NRM_W-1:0]      rsp_norm_x,
   output logic signed [ust_pkg::NRM_W-1:0]      rsp_norm_y,
   output logic signed [ust_pkg::NRM_W-1:0]      rsp_norm_z,
   output logic [ust_pkg::VIX_W-1:0]             rsp_vertex_index,
   output logic                                  rsp_last
);

   localparam int STEP_W = ust_pkg::STEP_W;
   localparam int VIX_W  = ust_pkg::VIX_W;

   ust_pkg::vert_type   item_ff;
   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [STEP_W-1:0]   last_step;
   logic [STEP_W-1:0]   t, c;
   logic                is_last, done, load, bot, show;
   logic [VIX_W-1:0]    k1, k2, corner;

   always_comb begin
      last_step = '0;
      if (!item_ff.meta.err) begin
         last_step = (item_ff.meta.top_en ? STEP_W'(3) : '0)
                   + (item_ff.meta.bot_en ? STEP_W'(3) : '0);
      end
   end

   assign is_last  = (step_ff == last_step);
   assign done     = busy_ff && rsp_ready && is_last;
   assign in_ready = !busy_ff || done;
   assign load     = in_valid && in_ready;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (load) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && rsp_ready) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_vert;
      end
   end

   // Corner beats: the upper triangle first when the cell has one.
   always_comb begin
      k1  = item_ff.meta.k1;
      k2  = k1 + VIX_W'(ns) + 1'b1;
      t   = step_ff - 1'b1;
      bot = !item_ff.meta.top_en || (t >= STEP_W'(3));
      c   = (item_ff.meta.top_en && (t >= STEP_W'(3))) ? t - STEP_W'(3) : t;
      if (!bot) begin
         unique case (c)
            STEP_W'(0): corner = k1;
            STEP_W'(1): corner = k2;
            default:    corner = k1 + 1'b1;
         endcase
      end else begin
         unique case (c)
            STEP_W'(0): corner = k1 + 1'b1;
            STEP_W'(1): corner = k2;
            default:    corner = k2 + 1'b1;
         endcase
      end
   end

   assign show      = !item_ff.meta.err && (step_ff == '0);
   assign rsp_valid = busy_ff;
   assign rsp_last  = is_last;
   assign rsp_kind  = item_ff.meta.err ? ust_pkg::KIND_ERR :
                      (step_ff == '0) ? ust_pkg::KIND_VERT : ust_pkg::KIND_TRI;
   assign rsp_pos_x  = show ? item_ff.pos_x  : '0;
   assign rsp_pos_y  = show ? item_ff.pos_y  : '0;
   assign rsp_pos_z  = show ? item_ff.pos_z  : '0;
   assign rsp_norm_x = show ? item_ff.norm_x : '0;
   assign rsp_norm_y = show ? item_ff.norm_y : '0;
   assign rsp_norm_z = show ? item_ff.norm_z : '0;
   assign rsp_vertex_index = item_ff.meta.err ? '0 : (step_ff == '0) ? k1 : corner;

endmodule

// ===== rtl/uv_sphere_tessellator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_tessellator
// Turns a (stack, sector) grid point into a UV sphere vertex with its normal
// and the corner indices of the grid cell below and right of it.
// ----------------------------------------------------------------------------
//   channel   ports                      direction   beat
//   config    psel/penable/pwrite/paddr  in/out      one register write or read
//   request   req_*                      in          one grid point
//   response  rsp_*                      out         one vertex, corner or error
//
// A grid point passes a pipeline of CORDIC_STEPS + 11 stages (input, four
// divider stages, angle split, one stage per CORDIC step, quadrant map and
// four multiply/round stages) before the emitter takes it. A point can enter
// each cycle while the pipeline moves; the response port sends one beat per
// cycle while rsp_ready is high, so a point with two triangles holds it for
// a vertex beat and six corner beats. Reset is synchronous and clears control
// state and the configuration registers. A point waiting at the last stage for
// a busy emitter, as in a response stall, freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator #(
   parameter int CORDIC_STEPS = ust_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ust_pkg::ADDR_W-1:0]            paddr,
   input  logic [ust_pkg::DATA_W-1:0]            pwdata,
   output logic [ust_pkg::DATA_W-1:0]            prdata,
   output logic                                  pready,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ust_pkg::CNT_W-1:0]             req_stack_index,
   input  logic [ust_pkg::CNT_W-1:0]             req_sector_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ust_pkg::KIND_W-1:0]            rsp_kind,
   output logic signed [ust_pkg::POS_W-1:0]      rsp_pos_x,
   output logic signed [ust_pkg::POS_W-1:0]      rsp_pos_y,
   output logic signed [ust_pkg::POS_W-1:0]      rsp_pos_z,
   output logic signed [ust_pkg::NRM_W-1:0]      rsp_norm_x,
   output logic signed [ust_pkg::NRM_W-1:0]      rsp_norm_y,
   output logic signed [ust_pkg::NRM_W-1:0]      rsp_norm_z,
   output logic [ust_pkg::VIX_W-1:0]             rsp_vertex_index,
   output logic                                  rsp_last
);

   localparam int CNT_W   = ust_pkg::CNT_W;
   localparam int RAD_W   = ust_pkg::RAD_W;
   localparam int ANG_W   = ust_pkg::ANG_W;
   localparam int CW      = ust_pkg::CW;
   localparam int CS_W    = ust_pkg::CS_W;
   localparam int POS_W   = ust_pkg::POS_W;
   localparam int NRM_W   = ust_pkg::NRM_W;
   localparam int VIX_W   = ust_pkg::VIX_W;
   localparam int DIV_STG = ust_pkg::DIV_STG;
   localparam int KW      = 2 * CNT_W + 1;
   localparam int XY_W    = 20;
   localparam int PR_W    = 2 * CS_W;
   localparam int NST     = CORDIC_STEPS + 11;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   logic [RAD_W-1:0] radius_ff;
   logic [CNT_W-1:0] sectors_ff, stacks_ff, ns, nt;
   logic             cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= ust_pkg::RADIUS_RST;
         sectors_ff <= ust_pkg::SECTORS_RST;
         stacks_ff  <= ust_pkg::STACKS_RST;
      end else if (cfg_wr) begin
         unique case (paddr[3:2])
            ust_pkg::REG_RADIUS:  radius_ff  <= pwdata[RAD_W-1:0];
            ust_pkg::REG_SECTORS: sectors_ff <= pwdata[CNT_W-1:0];
            ust_pkg::REG_STACKS:  stacks_ff  <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         ust_pkg::REG_RADIUS:  prdata = ust_pkg::DATA_W'(radius_ff);
         ust_pkg::REG_SECTORS: prdata = ust_pkg::DATA_W'(sectors_ff);
         ust_pkg::REG_STACKS:  prdata = ust_pkg::DATA_W'(stacks_ff);
         default:              prdata = '0;
      endcase
   end

   always_comb begin
      ns = sectors_ff;
      if (sectors_ff < CNT_W'(ust_pkg::MIN_SECTORS)) begin
         ns = CNT_W'(ust_pkg::MIN_SECTORS);
      end else if (32'(sectors_ff) > ust_pkg::MAX_SECTORS) begin
         ns = CNT_W'(ust_pkg::MAX_SECTORS);
      end
      nt = stacks_ff;
      if (stacks_ff < CNT_W'(ust_pkg::MIN_STACKS)) begin
         nt = CNT_W'(ust_pkg::MIN_STACKS);
      end else if (32'(stacks_ff) > ust_pkg::MAX_STACKS) begin
         nt = CNT_W'(ust_pkg::MAX_STACKS);
      end
   end

   // ------------------------------------------------------------------
   // Helper functions
   // ------------------------------------------------------------------
   function automatic logic [CNT_W+ANG_W-1:0] div_step(
      input logic [CNT_W-1:0] r_in, input logic [ANG_W-1:0] w_in,
      input logic [CNT_W-1:0] dv);
      logic [CNT_W:0]   rr;
      logic [CNT_W-1:0] r;
      logic [ANG_W-1:0] w;
      r = r_in;
      w = w_in;
      for (int b = 0; b < ust_pkg::DIV_PER_STG; b++) begin
         rr = {r, w[ANG_W-1]};
         w  = {w[ANG_W-2:0], 1'b0};
         if (rr >= {1'b0, dv}) begin
            rr   = rr - {1'b0, dv};
            w[0] = 1'b1;
         end
         r = rr[CNT_W-1:0];
      end
      return {r, w};
   endfunction

   // Rounds the angle to its nearest quadrant; the residual is signed.
   function automatic logic [CW+1:0] ang_split(input logic [ANG_W-1:0] a);
      logic [ANG_W-1:0] s, d;
      s = a + 32'h2000_0000;
      d = a - {s[ANG_W-1:ANG_W-2], 30'b0};
      return {s[ANG_W-1:ANG_W-2], CW'(signed'(d))};
   endfunction

   function automatic logic [3*CW-1:0] rot(
      input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
      input logic signed [CW-1:0] z, input int k);
      logic signed [CW-1:0] dx, dy, at, xn, yn, zn;
      dx = y >>> k;
      dy = x >>> k;
      at = CW'(ust_pkg::ATAN_TURNS[k]);
      if (!z[CW-1]) begin
         xn = x - dx;
         yn = y + dy;
         zn = z - at;
      end else begin
         xn = x + dx;
         yn = y - dy;
         zn = z + at;
      end
      return {xn, yn, zn};
   endfunction

   function automatic logic [2*CS_W-1:0] quad_map(
      input logic [1:0] q, input logic signed [CW-1:0] x,
      input logic signed [CW-1:0] y);
      logic signed [CW-1:0] c, s;
      unique case (q)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      return {CS_W'(c), CS_W'(s)};
   endfunction

   function automatic logic signed [63:0] rshift(input logic signed [63:0] v,
                                                 input int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > ust_pkg::POS_LIM) r = ust_pkg::POS_LIM;
      else if (v < -ust_pkg::POS_LIM) r = -ust_pkg::POS_LIM;
      return POS_W'(r);
   endfunction

   function automatic logic signed [NRM_W-1:0] sat_nrm(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > ust_pkg::NRM_LIM) r = ust_pkg::NRM_LIM;
      else if (v < -ust_pkg::NRM_LIM) r = -ust_pkg::NRM_LIM;
      return NRM_W'(r);
   endfunction

   // ------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------
   logic [NST-1:0]      v_ff;
   ust_pkg::meta_type   meta_ff [NST];
   ust_pkg::meta_type   meta_in;
   ust_pkg::vert_type   vert;
   logic                adv, em_ready;

   assign adv       = !v_ff[NST-1] || em_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0] <= meta_in;
         for (int s = 1; s < NST; s++) begin
            meta_ff[s] <= meta_ff[s-1];
         end
      end
   end

   // Input stage: range check, cell flags and the own vertex number.
   logic [KW-1:0] k1_wide;
   logic          in_cell;

   always_comb begin
      k1_wide = KW'(req_stack_index) * KW'({1'b0, ns} + 1'b1)
              + KW'(req_sector_index);
      in_cell = (req_stack_index < nt) && (req_sector_index < ns);
      meta_in.err    = (req_stack_index > nt) || (req_sector_index > ns);
      meta_in.top_en = in_cell && (req_stack_index != '0);
      meta_in.bot_en = in_cell && (req_stack_index != nt - 1'b1);
      meta_in.k1     = k1_wide[VIX_W-1:0];
   end

   // ------------------------------------------------------------------
   // Angle dividers: the remainder starts from the index bits above the
   // low word, then the low word shifts out while quotient bits shift in.
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] dsr_ff [DIV_STG+1];
   logic [CNT_W-1:0] dtr_ff [DIV_STG+1];
   logic [ANG_W-1:0] dsw_ff [DIV_STG+1];
   logic [ANG_W-1:0] dtw_ff [DIV_STG+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         dsr_ff[0] <= (req_sector_index >= ns) ? req_sector_index - ns : req_sector_index;
         dsw_ff[0] <= ANG_W'(ns >> 1);
         dtr_ff[0] <= {1'b0, req_stack_index[CNT_W-1:1]};
         dtw_ff[0] <= {req_stack_index[0], (ANG_W-1)'(nt >> 1)};
      end
   end

   for (genvar s = 1; s <= DIV_STG; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) begin
            {dsr_ff[s], dsw_ff[s]} <= div_step(dsr_ff[s-1], dsw_ff[s-1], ns);
            {dtr_ff[s], dtw_ff[s]} <= div_step(dtr_ff[s-1], dtw_ff[s-1], nt);
         end
      end
   end

   // ------------------------------------------------------------------
   // Quadrant split and CORDIC rotation, one step per stage
   // ------------------------------------------------------------------
   logic [1:0]           qt_ff [CORDIC_STEPS+1];
   logic [1:0]           qs_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] xt_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] yt_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] zt_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] xs_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] ys_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0] zs_ff [CORDIC_STEPS+1];
   logic [ANG_W-1:0]     a_st;

   assign a_st = 32'h4000_0000 - dtw_ff[DIV_STG];

   always_ff @(posedge clock) begin
      if (adv) begin
         {qt_ff[0], zt_ff[0]} <= ang_split(a_st);
         {qs_ff[0], zs_ff[0]} <= ang_split(dsw_ff[DIV_STG]);
         xt_ff[0] <= ust_pkg::CORDIC_GAIN;
         yt_ff[0] <= '0;
         xs_ff[0] <= ust_pkg::CORDIC_GAIN;
         ys_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      logic [3*CW-1:0] t_n, s_n;
      assign t_n = rot(xt_ff[k], yt_ff[k], zt_ff[k], k);
      assign s_n = rot(xs_ff[k], ys_ff[k], zs_ff[k], k);
      always_ff @(posedge clock) begin
         if (adv) begin
            qt_ff[k+1] <= qt_ff[k];
            qs_ff[k+1] <= qs_ff[k];
            {xt_ff[k+1], yt_ff[k+1], zt_ff[k+1]} <= t_n;
            {xs_ff[k+1], ys_ff[k+1], zs_ff[k+1]} <= s_n;
         end
      end
   end

   // ------------------------------------------------------------------
   // Quadrant map and scaling
   // ------------------------------------------------------------------
   logic signed [CS_W-1:0]      cu_ff, su_ff, cv_ff, sv_ff;
   logic signed [RAD_W+CS_W:0]  p_xy_ff, p_z_ff;
   logic signed [PR_W-1:0]      p_nx_ff, p_ny_ff;
   logic signed [CS_W-1:0]      su1_ff, cv1_ff, sv1_ff, cv2_ff, sv2_ff;
   logic signed [XY_W-1:0]      xy_ff;
   logic signed [POS_W-1:0]     pz2_ff, pz3_ff, px_ff, py_ff, pz4_ff;
   logic signed [NRM_W-1:0]     nx2_ff, ny2_ff, nz2_ff, nx3_ff, ny3_ff, nz3_ff;
   logic signed [NRM_W-1:0]     nx4_ff, ny4_ff, nz4_ff;
   logic signed [XY_W+CS_W-1:0] p_px_ff, p_py_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         {cu_ff, su_ff} <= quad_map(qt_ff[CORDIC_STEPS], xt_ff[CORDIC_STEPS],
                                    yt_ff[CORDIC_STEPS]);
         {cv_ff, sv_ff} <= quad_map(qs_ff[CORDIC_STEPS], xs_ff[CORDIC_STEPS],
                                    ys_ff[CORDIC_STEPS]);
         // First products.
         p_xy_ff <= $signed({1'b0, radius_ff}) * cu_ff;
         p_z_ff  <= $signed({1'b0, radius_ff}) * su_ff;
         p_nx_ff <= cu_ff * cv_ff;
         p_ny_ff <= cu_ff * sv_ff;
         su1_ff  <= su_ff;
         cv1_ff  <= cv_ff;
         sv1_ff  <= sv_ff;
         // Round; saturate all but xy_ff.
         xy_ff  <= XY_W'(rshift(64'(p_xy_ff), 30));
         pz2_ff <= sat_pos(rshift(64'(p_z_ff), 30));
         nx2_ff <= sat_nrm(rshift(64'(p_nx_ff), 45));
         ny2_ff <= sat_nrm(rshift(64'(p_ny_ff), 45));
         nz2_ff <= sat_nrm(rshift(64'(su1_ff), 15));
         cv2_ff <= cv1_ff;
         sv2_ff <= sv1_ff;
         // Horizontal position products.
         p_px_ff <= xy_ff * cv2_ff;
         p_py_ff <= xy_ff * sv2_ff;
         pz3_ff  <= pz2_ff;
         nx3_ff  <= nx2_ff;
         ny3_ff  <= ny2_ff;
         nz3_ff  <= nz2_ff;
         // Final rounding.
         px_ff  <= sat_pos(rshift(64'(p_px_ff), 30));
         py_ff  <= sat_pos(rshift(64'(p_py_ff), 30));
         pz4_ff <= pz3_ff;
         nx4_ff <= nx3_ff;
         ny4_ff <= ny3_ff;
         nz4_ff <= nz3_ff;
      end
   end

   always_comb begin
      vert.meta   = meta_ff[NST-1];
      vert.pos_x  = px_ff;
      vert.pos_y  = py_ff;
      vert.pos_z  = pz4_ff;
      vert.norm_x = nx4_ff;
      vert.norm_y = ny4_ff;
      vert.norm_z = nz4_ff;
   end

   ust_emitter u_emitter (
      .clock            (clock),
      .reset            (reset),
      .ns               (ns),
      .in_valid         (v_ff[NST-1]),
      .in_ready         (em_ready),
      .in_vert          (vert),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_norm_x       (rsp_norm_x),
      .rsp_norm_y       (rsp_norm_y),
      .rsp_norm_z       (rsp_norm_z),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last         (rsp_last)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == ust_pkg::KIND_ERR) |-> rsp_last)
      else $error("range error beat is not the last beat");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (v_ff == $past(v_ff)))
      else $error("pipeline valid bits moved during a stall");

   a_tri_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != ust_pkg::KIND_VERT)
      |-> (rsp_pos_x == '0) && (rsp_norm_z == '0))
      else $error("non-vertex beat carries vertex data");

endmodule
